### sv/pas_pkg.sv
// ----------------------------------------------------------------------------
// pas_pkg: shared types for the Paxos acceptor
// Request kinds, request/result words, acceptor state and proposal ordering.
// ----------------------------------------------------------------------------
package pas_pkg;

  typedef enum logic [1:0] {
    MODE_PREPARE = 2'd0,
    MODE_ACCEPT  = 2'd1,
    MODE_DECIDE  = 2'd2,
    MODE_COMMIT  = 2'd3
  } mode_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] instance_req;
    logic [31:0] prop_round;
    logic [15:0] prop_node;
    logic [31:0] value;
  } req_t;

  typedef struct packed {
    logic        old_instance;
    logic        granted;
    logic [31:0] prev_round;
    logic [15:0] prev_node;
    logic [31:0] prev_value;
    logic        committed;
    logic [31:0] commit_instance;
    logic [31:0] commit_value;
    logic        behind;
  } res_t;

  typedef struct packed {
    logic [31:0] promised_round;
    logic [15:0] promised_node;
    logic [31:0] accepted_round;
    logic [15:0] accepted_node;
    logic [31:0] accepted_value;
    logic [31:0] decided_instance;
  } acc_state_t;

  // (ra, na) above (rb, nb); ties on both parts pass only when allow_eq is set
  function automatic logic prop_above(input logic [31:0] ra, input logic [15:0] na,
                                      input logic [31:0] rb, input logic [15:0] nb,
                                      input logic allow_eq);
    logic r;
    if (ra != rb) begin
      r = (ra > rb);
    end else if (allow_eq) begin
      r = (na >= nb);
    end else begin
      r = (na > nb);
    end
    return r;
  endfunction

endpackage

### sv/pas_if.sv
// ----------------------------------------------------------------------------
// pas_if: request and result channels
// Valid/ready channels carrying one request word and one result word.
// ----------------------------------------------------------------------------
interface pas_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [31:0] instance_req;
  logic [31:0] prop_round;
  logic [15:0] prop_node;
  logic [31:0] value;

  modport source (output valid, mode, instance_req, prop_round, prop_node, value,
                  input ready);
  modport sink   (input valid, mode, instance_req, prop_round, prop_node, value,
                  output ready);
endinterface

interface pas_res_if;
  logic        valid;
  logic        ready;
  logic        old_instance;
  logic        granted;
  logic [31:0] prev_round;
  logic [15:0] prev_node;
  logic [31:0] prev_value;
  logic        committed;
  logic [31:0] commit_instance;
  logic [31:0] commit_value;
  logic        behind;

  modport source (output valid, old_instance, granted, prev_round, prev_node,
                  prev_value, committed, commit_instance, commit_value, behind,
                  input ready);
  modport sink   (input valid, old_instance, granted, prev_round, prev_node,
                  prev_value, committed, commit_instance, commit_value, behind,
                  output ready);
endinterface

### sv/pas_eval.sv
// ----------------------------------------------------------------------------
// pas_eval: acceptor decision logic
// Computes the result word and the next acceptor state for one request.
// ----------------------------------------------------------------------------
module pas_eval
  import pas_pkg::*;
(
  input  req_t       req,
  input  acc_state_t state,
  input  logic [15:0] self_id,
  output acc_state_t state_next,
  output res_t       res
);

  logic [31:0] next_inst;
  logic        inst_new;
  logic        do_commit;

  assign next_inst = state.decided_instance + 32'd1;
  assign inst_new  = (req.instance_req > state.decided_instance);

  always_comb begin
    state_next = state;
    res        = '0;
    do_commit  = 1'b0;
    case (mode_t'(req.mode))
      MODE_PREPARE: begin
        if (!inst_new) begin
          res.old_instance = 1'b1;
          res.prev_value   = state.accepted_value;
        end else if (prop_above(req.prop_round, req.prop_node,
                                state.promised_round, state.promised_node, 1'b0)) begin
          state_next.promised_round = req.prop_round;
          state_next.promised_node  = req.prop_node;
          res.granted    = 1'b1;
          res.prev_round = state.accepted_round;
          res.prev_node  = state.accepted_node;
          res.prev_value = state.accepted_value;
        end
      end
      MODE_ACCEPT: begin
        if (prop_above(req.prop_round, req.prop_node,
                       state.promised_round, state.promised_node, 1'b1)) begin
          state_next.accepted_round = req.prop_round;
          state_next.accepted_node  = req.prop_node;
          state_next.accepted_value = req.value;
          res.granted = 1'b1;
        end
      end
      MODE_DECIDE: begin
        // wrap case: next_inst of zero fails inst_new, so nothing commits
        if (req.instance_req == next_inst) begin
          do_commit = inst_new;
        end else if (inst_new) begin
          res.behind = 1'b1;
        end
      end
      MODE_COMMIT: begin
        do_commit = inst_new;
      end
      default: begin
        do_commit = 1'b0;
      end
    endcase

    if (do_commit) begin
      state_next.decided_instance = req.instance_req;
      state_next.promised_round   = '0;
      state_next.promised_node    = self_id;
      state_next.accepted_round   = '0;
      state_next.accepted_node    = self_id;
      state_next.accepted_value   = '0;
      res.committed       = 1'b1;
      res.commit_instance = req.instance_req;
      res.commit_value    = req.value;
    end
  end

endmodule

### sv/paxos_acceptor_step.sv
// ----------------------------------------------------------------------------
// paxos_acceptor_step: single-instance Paxos acceptor
// Pipeline: a request word passes the input stage, then the result stage.
// Throughput: one request per cycle while the result sink does not stall; the
//   state update of one request is seen by the very next one, as evaluation and state write share a cycle.
// Reset (rst, synchronous, active high): empties both stages, clears all
//   proposals, the accepted value, the decided instance and self_id to zero.
// ----------------------------------------------------------------------------
module paxos_acceptor_step
  import pas_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  pas_req_if.sink     req,
  pas_res_if.source   res
);

  // Input stage: holds the request word waiting for evaluation.
  req_t       req_q;
  logic       req_q_valid;
  // Result stage: holds the finished result word until the sink takes it.
  res_t       res_q;
  logic       res_q_valid;
  // Acceptor state and configuration.
  acc_state_t state;
  acc_state_t state_next;
  logic [15:0] self_id;
  res_t       res_d;
  req_t       req_in;
  logic       adv;

  // Advance the input stage whenever the result stage is free or draining.
  assign adv       = !res_q_valid || res.ready;
  assign req.ready = !req_q_valid || adv;

  assign req_in.mode         = req.mode;
  assign req_in.instance_req = req.instance_req;
  assign req_in.prop_round   = req.prop_round;
  assign req_in.prop_node    = req.prop_node;
  assign req_in.value        = req.value;

  pas_eval u_eval (
    .req        (req_q),
    .state      (state),
    .self_id    (self_id),
    .state_next (state_next),
    .res        (res_d)
  );

  // Self id only takes effect at the next decision; stored proposals stay.
  always_ff @(posedge clk) begin
    if (rst) begin
      self_id <= '0;
    end else if (cfg_wr_en) begin
      self_id <= cfg_wr_data;
    end
  end

  // Input register: take a new word whenever there is room.
  always_ff @(posedge clk) begin
    if (rst) begin
      req_q_valid <= 1'b0;
    end else if (req.ready) begin
      req_q_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      req_q <= req_in;
    end
  end

  // Result register and state commit together, so each word updates once.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_q_valid <= 1'b0;
      state       <= '0;
    end else if (adv) begin
      res_q_valid <= req_q_valid;
      if (req_q_valid) begin
        state <= state_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && req_q_valid) begin
      res_q <= res_d;
    end
  end

  assign res.valid           = res_q_valid;
  assign res.old_instance    = res_q.old_instance;
  assign res.granted         = res_q.granted;
  assign res.prev_round      = res_q.prev_round;
  assign res.prev_node       = res_q.prev_node;
  assign res.prev_value      = res_q.prev_value;
  assign res.committed       = res_q.committed;
  assign res.commit_instance = res_q.commit_instance;
  assign res.commit_value    = res_q.commit_value;
  assign res.behind          = res_q.behind;

  // A commit leaves both proposals at round zero and the value empty.
  a_commit_clears: assert property (@(posedge clk) disable iff (rst)
    (adv && req_q_valid && res_d.committed) |=>
      (state.promised_round == 32'd0 && state.accepted_round == 32'd0 &&
       state.accepted_value == 32'd0))
    else $error("commit did not clear acceptor state");

  // The decided instance never moves backward outside reset.
  a_decided_monotonic: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (state.decided_instance >= $past(state.decided_instance)))
    else $error("decided instance decreased");

  // A result never both grants and commits.
  a_grant_xor_commit: assert property (@(posedge clk) disable iff (rst)
    res_q_valid |-> !(res_q.granted && res_q.committed))
    else $error("result both granted and committed");

  // A stalled input word holds its place and its contents.
  a_input_hold: assert property (@(posedge clk) disable iff (rst)
    (req_q_valid && !adv) |=> (req_q_valid && $stable(req_q)))
    else $error("stalled request word lost");

endmodule
